// File: design/tga_rle_pixel_decoder_macros.svh
// Assertion macros used by the decoder's top-level RTL file.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGARLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGARLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tgarle_pkg.sv
// Types and constants shared by the TGA RLE pixel decoder modules.
package tgarle_pkg;

    localparam int unsigned RUN_BIT = 7;
    localparam logic [2:0] BPP_THREE = 3'd3;
    localparam logic [2:0] BPP_FOUR = 3'd4;

    localparam logic        RLE_MODE_RST = 1'b0;
    localparam logic [2:0]  PIXEL_BYTES_RST = 3'd4;
    localparam logic [31:0] PIXEL_TOTAL_RST = 32'd1;

    typedef enum logic [1:0] {
        REG_RLE_MODE    = 2'd0,
        REG_PIXEL_BYTES = 2'd1,
        REG_PIXEL_TOTAL = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic        rle_mode;
        logic [2:0]  pixel_bytes;
        logic [31:0] pixel_total;
    } cfg_t;

    // One decoded pixel as handed from the front end to the back end.
    typedef struct packed {
        logic [23:0] gather;
        logic [7:0]  last_byte;
        logic        four_byte;
        logic [7:0]  rep;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] rep;
        logic       done;
    } res_t;

    typedef struct packed {
        logic complete;
        logic tok_push;
    } front_stat_t;

endpackage

// File: design/tgarle_front.sv
// Front end: packet parsing, pixel byte gathering and pixel counting.
module tgarle_front import tgarle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        byte_valid,
    input  logic [7:0]  data_byte,
    input  logic        tok_full,
    output tok_t        tok,
    output front_stat_t stat
);

    logic        hdr_reg, hdr_next;
    logic        run_reg, run_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  slot_reg, slot_next;
    logic [23:0] gather_reg, gather_next;
    logic [31:0] done_reg, done_next;

    logic        accept;
    logic        four;
    logic        complete;
    logic [2:0]  slot_inc;
    logic [2:0]  bpp;
    logic [7:0]  left_eff;
    logic [7:0]  rep_raw;
    logic [31:0] remaining;
    logic        clip;
    logic        last;
    logic        tok_push;

    always_comb
    begin
        accept = byte_valid && !tok_full;
        four = (cfg.pixel_bytes != BPP_THREE);
        bpp = four ? BPP_FOUR : BPP_THREE;
        complete = (done_reg >= cfg.pixel_total);
        slot_inc = {1'b0, slot_reg} + 3'd1;
        left_eff = (left_reg == 8'd0) ? 8'd1 : left_reg;
        rep_raw = (cfg.rle_mode && run_reg) ? left_eff : 8'd1;

        // A run never goes past the end of the image.
        remaining = cfg.pixel_total - done_reg;
        clip = (remaining[31:8] == 24'd0) && (remaining[7:0] < rep_raw);
        last = clip || (remaining == {24'd0, rep_raw});

        hdr_next = hdr_reg;
        run_next = run_reg;
        left_next = left_reg;
        slot_next = slot_reg;
        gather_next = gather_reg;
        done_next = done_reg;
        tok_push = 1'b0;

        if (accept && !complete)
        begin
            if (cfg.rle_mode && hdr_reg)
            begin
                run_next = data_byte[RUN_BIT];
                left_next = {1'b0, data_byte[6:0]} + 8'd1;
                hdr_next = 1'b0;
                slot_next = 2'd0;
            end
            else if (slot_inc < bpp)
            begin
                case (slot_reg)
                    2'd0:    gather_next[7:0] = data_byte;
                    2'd1:    gather_next[15:8] = data_byte;
                    default: gather_next[23:16] = data_byte;
                endcase
                slot_next = slot_inc[1:0];
            end
            else
            begin
                slot_next = 2'd0;
                tok_push = 1'b1;
                if (cfg.rle_mode)
                begin
                    if (run_reg)
                    begin
                        left_next = 8'd0;
                        hdr_next = 1'b1;
                    end
                    else
                    begin
                        left_next = left_eff - 8'd1;
                        hdr_next = (left_eff == 8'd1);
                    end
                end
                done_next = last ? cfg.pixel_total : done_reg + {24'd0, rep_raw};
            end
        end

        tok.gather = gather_reg;
        tok.last_byte = data_byte;
        tok.four_byte = four;
        tok.rep = clip ? remaining[7:0] : rep_raw;
        tok.last = last;

        stat.complete = complete;
        stat.tok_push = tok_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= 1'b1;
            run_reg <= 1'b0;
            left_reg <= 8'd0;
            slot_reg <= 2'd0;
            gather_reg <= 24'd0;
            done_reg <= 32'd0;
        end
        else
        begin
            hdr_reg <= hdr_next;
            run_reg <= run_next;
            left_reg <= left_next;
            slot_reg <= slot_next;
            gather_reg <= gather_next;
            done_reg <= done_next;
        end
    end

endmodule

// File: design/tgarle_queue.sv
// Two-entry queue of decoded pixels between the front end and the back end.
module tgarle_queue import tgarle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tok_t din,
    output logic full,
    input  logic pop,
    output tok_t dout,
    output logic empty
);

    tok_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        full = (count_reg == 2'd2);
        empty = (count_reg == 2'd0);
        do_push = push && !full;
        do_pop = pop && !empty;
        dout = entry_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: design/tgarle_back.sv
// Back end: channel reordering into RGBA and the result queue.
module tgarle_back import tgarle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tok,
    input  logic tok_empty,
    output logic tok_pop,
    input  logic pop,
    output res_t res,
    output logic empty
);

    res_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;
    res_t       conv;

    always_comb
    begin
        // BGR pixels take red from the final byte; BGRA pixels take alpha from it.
        conv.blue = tok.gather[7:0];
        conv.green = tok.gather[15:8];
        conv.red = tok.four_byte ? tok.gather[23:16] : tok.last_byte;
        conv.alpha = tok.four_byte ? tok.last_byte : 8'd0;
        conv.rep = tok.rep;
        conv.done = tok.last;

        tok_pop = !tok_empty && (count_reg != 2'd2);
        empty = (count_reg == 2'd0);
        do_pop = pop && !empty;
        res = entry_reg[rd_ptr_reg];
        wr_ptr_next = tok_pop ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, tok_pop} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop)
        begin
            entry_reg[wr_ptr_reg] <= conv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: design/tga_rle_pixel_decoder.sv
// Top level of the TGA RLE pixel decoder: configuration registers and datapath.
//
// Channel   Handshake              Payload
// input     push / full            data_byte
// result    pop / empty            red, green, blue, alpha, repeat_res, image_done
// config    APB write/read         rle_mode @0x0, pixel_bytes @0x4, pixel_total @0x8
//
// One byte is accepted per cycle while full is low; a byte that completes a pixel goes
// into the pixel queue, then the result queue, whose head drives the result ports for pop.
// Packet state and the pixel count are updated in the front end in the cycle a byte arrives.
// Reset clears all decoding state and puts the registers at their reset values.
// Each side stalls on its own: full rises only when the pixel queue holds two entries.
`include "tga_rle_pixel_decoder_macros.svh"

module tga_rle_pixel_decoder import tgarle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    input  logic [7:0]  data_byte,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [7:0]  repeat_res,
    output logic        image_done
);

    cfg_t        cfg_reg, cfg_next;
    reg_idx_t    reg_idx;
    logic        cfg_write;
    tok_t        tok_in;
    tok_t        tok_out;
    front_stat_t stat;
    logic        tok_full;
    logic        tok_empty;
    logic        tok_pop;
    res_t        res;

    always_comb
    begin
        pready = 1'b1;
        reg_idx = reg_idx_t'(paddr[3:2]);
        cfg_write = psel && penable && pwrite && pready;
        cfg_next = cfg_reg;
        prdata = 32'd0;
        unique case (reg_idx)
            REG_RLE_MODE:
            begin
                prdata = {31'd0, cfg_reg.rle_mode};
                if (cfg_write)
                begin
                    cfg_next.rle_mode = pwdata[0];
                end
            end
            REG_PIXEL_BYTES:
            begin
                prdata = {29'd0, cfg_reg.pixel_bytes};
                if (cfg_write)
                begin
                    cfg_next.pixel_bytes = pwdata[2:0];
                end
            end
            REG_PIXEL_TOTAL:
            begin
                prdata = cfg_reg.pixel_total;
                if (cfg_write)
                begin
                    cfg_next.pixel_total = pwdata;
                end
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rle_mode <= RLE_MODE_RST;
            cfg_reg.pixel_bytes <= PIXEL_BYTES_RST;
            cfg_reg.pixel_total <= PIXEL_TOTAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tgarle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (push),
        .data_byte  (data_byte),
        .tok_full   (tok_full),
        .tok        (tok_in),
        .stat       (stat)
    );

    tgarle_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (stat.tok_push),
        .din   (tok_in),
        .full  (tok_full),
        .pop   (tok_pop),
        .dout  (tok_out),
        .empty (tok_empty)
    );

    tgarle_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok_out),
        .tok_empty (tok_empty),
        .tok_pop   (tok_pop),
        .pop       (pop),
        .res       (res),
        .empty     (empty)
    );

    always_comb
    begin
        full = tok_full;
        red = res.red;
        green = res.green;
        blue = res.blue;
        alpha = res.alpha;
        repeat_res = res.rep;
        image_done = res.done;
    end

    `TGARLE_ASSERT_SAME(a_rep_nonzero, !empty, repeat_res != 8'd0, "result with zero repeat")
    `TGARLE_ASSERT_SAME(a_no_pixel_after_end, stat.complete, !stat.tok_push, "pixel after image end")
    `TGARLE_ASSERT_SAME(a_done_means_complete, !empty && image_done, stat.complete, "image_done without completed count")
    `TGARLE_ASSERT_NEXT(a_pixel_reaches_queue, stat.tok_push, !tok_empty, "pixel lost before queue")

endmodule

// File: verif/tb.sv
// Self-checking testbench for the TGA RLE pixel decoder: directed cases, then random streams.
`timescale 1ns / 100ps

module tb import tgarle_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BYTES = 1350;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        full;
    logic        pop = 1'b0;
    logic        empty;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic        image_done;

    // Register copies and decoding state of the prediction.
    logic        cfg_rle;
    logic [2:0]  cfg_bpp;
    logic [31:0] cfg_total;
    logic        want_packet;
    logic        in_run;
    logic [7:0]  packet_pixels;
    logic [1:0]  slot;
    logic [23:0] gather;
    logic [31:0] pixels_out;

    res_t        pending_pixels[$];
    int unsigned bytes_sent = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned stall_step = 0;

    tga_rle_pixel_decoder u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tga_rle_pixel_decoder verification failed");
            $finish;
        end
    end

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Advances the predicted decoder by one byte. Returns 0 when the byte is ignored
    // because the image is already complete.
    function automatic bit decode_byte(input logic [7:0] b);
        int unsigned width;
        int unsigned left;
        int unsigned rep;
        int unsigned remaining;
        res_t px;
        width = (cfg_bpp == BPP_THREE) ? 3 : 4;
        if (pixels_out >= cfg_total)
            return 1'b0;
        if (cfg_rle && want_packet)
        begin
            in_run = b[RUN_BIT];
            packet_pixels = {1'b0, b[6:0]} + 8'd1;
            want_packet = 1'b0;
            slot = '0;
            return 1'b1;
        end
        if (slot + 1 < width)
        begin
            gather[slot * 8 +: 8] = b;
            slot = slot + 2'd1;
            return 1'b1;
        end
        px.blue = gather[7:0];
        px.green = gather[15:8];
        if (width == 3)
        begin
            px.red = b;
            px.alpha = 8'd0;
        end
        else
        begin
            px.red = gather[23:16];
            px.alpha = b;
        end
        slot = '0;
        rep = 1;
        if (cfg_rle)
        begin
            left = (packet_pixels != 0) ? packet_pixels : 1;
            if (in_run)
            begin
                rep = left;
                packet_pixels = '0;
            end
            else
                packet_pixels = 8'(left - 1);
            if (packet_pixels == 0)
                want_packet = 1'b1;
        end
        remaining = cfg_total - pixels_out;
        if (rep > remaining)
            rep = remaining;
        pixels_out = pixels_out + rep;
        px.rep = 8'(rep);
        px.done = (pixels_out == cfg_total);
        pending_pixels.push_back(px);
        return 1'b1;
    endfunction

    // Sends one byte, inserting a random gap at the start of most bursts.
    task automatic feed_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 6))
                begin
                    @(negedge clk);
                    push <= 1'b0;
                end
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (full);
        bytes_sent++;
        void'(decode_byte(b));
    endtask

    // Stops sending and waits until every predicted pixel has come out, plus a margin
    // for bytes still inside the pipeline that produce nothing.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] stored;
        settle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_RLE_MODE:
            begin
                cfg_rle = value[0];
                stored = {31'b0, value[0]};
            end
            REG_PIXEL_BYTES:
            begin
                cfg_bpp = value[2:0];
                stored = {29'b0, value[2:0]};
            end
            default:
            begin
                cfg_total = value;
                stored = value;
            end
        endcase
        // Read the register straight back in a second transaction.
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
            note_mismatch("register readback", stored, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // The receiver stalls on a 16-bit pattern that is picked anew as stall_step advances.
    always @(negedge clk)
    begin
        if (stall_step % 48 == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= 16'hFFFF;
                1: stall_pattern <= 16'($urandom);
                2: stall_pattern <= 16'h8000 | (16'($urandom) & 16'($urandom) & 16'($urandom));
                default: stall_pattern <= 16'($urandom) | 16'($urandom);
            endcase
        end
        pop <= stall_pattern[stall_step % 16];
        stall_step <= stall_step + 1;
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel transaction with none expected: rgba %h%h%h%h rep %0d",
                             red, green, blue, alpha, repeat_res);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (red !== want.red)
                    note_mismatch("red", want.red, red);
                if (green !== want.green)
                    note_mismatch("green", want.green, green);
                if (blue !== want.blue)
                    note_mismatch("blue", want.blue, blue);
                if (alpha !== want.alpha)
                    note_mismatch("alpha", want.alpha, alpha);
                if (repeat_res !== want.rep)
                    note_mismatch("repeat_res", want.rep, repeat_res);
                if (image_done !== want.done)
                    note_mismatch("image_done", want.done, image_done);
            end
        end
    end

    // Register values after reset: raw data, four bytes per pixel, one pixel.
    task automatic test_reset_config();
        feed_byte(8'h00);
        feed_byte(8'hFF);
        feed_byte(8'h00);
        feed_byte(8'hFF);
    endtask

    task automatic test_zero_total();
        write_reg(REG_PIXEL_TOTAL, 32'd0);
        feed_byte(8'hC3);
    endtask

    task automatic test_raw_three_byte();
        write_reg(REG_PIXEL_BYTES, 32'(BPP_THREE));
        write_reg(REG_PIXEL_TOTAL, pixels_out + 32'd2);
        feed_byte(8'hFF);
        feed_byte(8'h00);
        feed_byte(8'h81);
    endtask

    // Longest run, with a pixel size that is neither three nor four.
    task automatic test_run_extremes();
        write_reg(REG_RLE_MODE, 32'd1);
        write_reg(REG_PIXEL_BYTES, 32'd7);
        write_reg(REG_PIXEL_TOTAL, pixels_out + 32'd300);
        feed_byte(8'hFF);
        feed_byte(8'h12);
        feed_byte(8'h34);
        feed_byte(8'h56);
        feed_byte(8'h78);
    endtask

    // A run longer than what is left of the image; the byte after it is ignored.
    task automatic test_run_clipped();
        write_reg(REG_PIXEL_TOTAL, pixels_out + 32'd5);
        feed_byte(8'h8A);
        feed_byte(8'hA5);
        feed_byte(8'h5A);
        feed_byte(8'h0F);
        feed_byte(8'hF0);
        feed_byte(8'h33);
    endtask

    // A raw packet interrupted by raw mode keeps its state and resumes afterwards.
    task automatic test_mode_switch();
        write_reg(REG_PIXEL_BYTES, 32'(BPP_THREE));
        write_reg(REG_PIXEL_TOTAL, pixels_out + 32'd50);
        feed_byte(8'h01);
        feed_byte(8'h11);
        feed_byte(8'h22);
        feed_byte(8'h33);
        write_reg(REG_RLE_MODE, 32'd0);
        feed_byte(8'h44);
        feed_byte(8'h55);
        feed_byte(8'h66);
        write_reg(REG_RLE_MODE, 32'd1);
        feed_byte(8'h77);
        feed_byte(8'h88);
        feed_byte(8'h99);
    endtask

    // Phases with random settings. A packet byte is generated whenever the decoder
    // expects one, so most of the stream is well formed.
    task automatic test_random_stream();
        int unsigned start;
        int unsigned phase_bytes;
        int unsigned sent;
        int unsigned roll;
        logic [31:0] total;
        logic [7:0] b;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            write_reg(REG_RLE_MODE, {31'($urandom), ($urandom_range(0, 3) != 0)});
            roll = $urandom_range(0, 9);
            if (roll < 4)
                write_reg(REG_PIXEL_BYTES, {29'($urandom), BPP_THREE});
            else if (roll < 8)
                write_reg(REG_PIXEL_BYTES, {29'($urandom), BPP_FOUR});
            else
                write_reg(REG_PIXEL_BYTES, $urandom);
            phase_bytes = $urandom_range(30, 160);
            roll = $urandom_range(0, 19);
            if (roll == 0)
            begin
                total = 32'd0;
                phase_bytes = 4;
            end
            else if (roll == 1)
                total = 32'hFFFF_FFFF;
            else if (roll < 5)
                total = pixels_out + $urandom_range(1, 40);
            else
                total = pixels_out + $urandom_range(200, 4000);
            write_reg(REG_PIXEL_TOTAL, total);
            for (sent = 0; sent < phase_bytes; sent++)
            begin
                if (cfg_rle && want_packet)
                begin
                    b[7] = 1'($urandom);
                    if (b[7] || $urandom_range(0, 7) == 0)
                        b[6:0] = 7'($urandom);
                    else
                        b[6:0] = 7'($urandom_range(0, 7));
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        default: b = 8'($urandom);
                    endcase
                end
                feed_byte(b);
            end
        end
    endtask

    initial
    begin
        cfg_rle = RLE_MODE_RST;
        cfg_bpp = PIXEL_BYTES_RST;
        cfg_total = PIXEL_TOTAL_RST;
        want_packet = 1'b1;
        in_run = 1'b0;
        packet_pixels = '0;
        slot = '0;
        gather = '0;
        pixels_out = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_config();
        test_zero_total();
        test_raw_three_byte();
        test_run_extremes();
        test_run_clipped();
        test_mode_switch();
        test_random_stream();
        settle();

        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("tga_rle_pixel_decoder verification clean");
        else
            $display("tga_rle_pixel_decoder verification failed");
        $finish;
    end

endmodule
